### design/lsur_pkg.sv
// Shared constants and controller/datapath handshake types for the
// lagged subtractive uniform generator. No dependencies.
package lsur_pkg;

    localparam int LAG_LONG   = 55;
    localparam int LAG_SHORT  = 24;
    localparam int LAG_DIFF   = 31;
    localparam int SCATTER    = 21;
    localparam int WORD_W     = 28;
    localparam int IDX_W      = 6;
    localparam int DATA_W     = 32;
    localparam int FRAC_STEPS = 28;
    localparam int STEP_W     = 5;

    localparam logic [IDX_W-1:0]  IDX_LAST   = IDX_W'(LAG_LONG - 1);
    localparam logic [STEP_W-1:0] STEP_LAST  = STEP_W'(FRAC_STEPS - 1);
    localparam logic [DATA_W-1:0] HALF_ONE   = 32'h0800_0000;
    localparam logic [DATA_W-1:0] INT_TOP    = 32'h7FFF_FFFF;

    // Commands from controller to datapath
    typedef struct packed {
        logic seed_load;   // normalize seed, start scattered fill
        logic seed_step;   // write one scattered entry, advance recurrence
        logic rf_read;     // issue reads for one refill entry
        logic rf_write;    // write one refilled entry, advance entry counter
        logic draw_start;  // capture bound, step read pointer
        logic draw_read;   // issue read of the drawn entry
        logic scale_load;  // load fraction and start product
        logic scale_step;  // one halving step
        logic out_load;    // load the output register
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic seed_last;
        logic rf_last;
        logic ptr_zero;
        logic scale_last;
        logic out_free;
    } sts_t;

endpackage

### design/lsur_ram.sv
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
module lsur_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 55,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    output logic [WIDTH-1:0] rdata_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

### design/lsur_ctrl.sv
// Sequencing state machine for seeding, table refill and draws.
// Depends on lsur_pkg.
module lsur_ctrl
    import lsur_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [8:0] {
        ST_SEED_INIT = 9'b000000001,
        ST_SEED_FILL = 9'b000000010,
        ST_RF_READ   = 9'b000000100,
        ST_RF_WRITE  = 9'b000001000,
        ST_IDLE      = 9'b000010000,
        ST_DRAW_READ = 9'b000100000,
        ST_DRAW_LOAD = 9'b001000000,
        ST_SCALE     = 9'b010000000,
        ST_DONE      = 9'b100000000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] pass_reg, pass_next;   // refill passes left, current one included
    logic       draw_reg, draw_next;   // refill was triggered by a draw

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        draw_next  = draw_reg;
        cmd        = '0;
        case (state_reg)
            ST_SEED_INIT:
            begin
                cmd.seed_load = 1'b1;
                state_next    = ST_SEED_FILL;
            end
            ST_SEED_FILL:
            begin
                cmd.seed_step = 1'b1;
                if (sts.seed_last)
                begin
                    pass_next  = 2'd3;
                    draw_next  = 1'b0;
                    state_next = ST_RF_READ;
                end
            end
            ST_RF_READ:
            begin
                cmd.rf_read = 1'b1;
                state_next  = ST_RF_WRITE;
            end
            ST_RF_WRITE:
            begin
                cmd.rf_write = 1'b1;
                state_next   = ST_RF_READ;
                if (sts.rf_last)
                begin
                    pass_next = pass_reg - 2'd1;
                    if (pass_reg == 2'd1)
                    begin
                        state_next = draw_reg ? ST_DRAW_READ : ST_IDLE;
                    end
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.draw_start = 1'b1;
                    if (sts.ptr_zero)
                    begin
                        pass_next  = 2'd1;
                        draw_next  = 1'b1;
                        state_next = ST_RF_READ;
                    end
                    else
                    begin
                        state_next = ST_DRAW_READ;
                    end
                end
            end
            ST_DRAW_READ:
            begin
                cmd.draw_read = 1'b1;
                state_next    = ST_DRAW_LOAD;
            end
            ST_DRAW_LOAD:
            begin
                cmd.scale_load = 1'b1;
                state_next     = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.scale_step = 1'b1;
                if (sts.scale_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_SEED_INIT;
            end
        endcase
        // a seed write restarts seeding
        if (cfg_we)
        begin
            state_next = ST_SEED_INIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SEED_INIT;
            pass_reg  <= 2'd0;
            draw_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            draw_reg  <= draw_next;
        end
    end

endmodule

### design/lsur_dp.sv
// Datapath: seed register, lag table RAM, seeding recurrence, refill,
// read pointer, halving multiplier and output register.
// Depends on lsur_pkg and lsur_ram.
module lsur_dp
    import lsur_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output sts_t              sts,
    input  logic              cfg_we,
    input  logic [DATA_W-1:0] cfg_wdata,
    input  logic [DATA_W-1:0] s_tdata,
    input  logic              m_tready,
    output logic              m_tvalid,
    output logic [DATA_W-1:0] m_tdata
);

    logic [DATA_W-1:0] seed_reg;

    // seeding recurrence
    logic [WORD_W-1:0] a_reg, a_next;
    logic [WORD_W-1:0] b_reg, b_next;
    logic [IDX_W-1:0]  sidx_reg, sidx_next;
    logic [IDX_W-1:0]  scnt_reg, scnt_next;

    // refill and draw
    logic [IDX_W-1:0]  k_reg, k_next;
    logic [IDX_W-1:0]  ptr_reg, ptr_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DATA_W-1:0] p_reg, p_next;
    logic [WORD_W-1:0] f_reg, f_next;
    logic [DATA_W-1:0] q_reg;
    logic              neg_reg;
    logic              mvalid_reg;
    logic [DATA_W-1:0] mdata_reg;

    logic [DATA_W-1:0] seed_mag;
    logic [WORD_W-1:0] seed_norm;
    logic [IDX_W:0]    sidx_sum;
    logic [IDX_W-1:0]  partner;
    logic [DATA_W:0]   p_sum;
    logic [DATA_W-1:0] y_sat;
    logic [DATA_W-1:0] result;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [IDX_W-1:0]  ram_raddr_a;
    logic [WORD_W-1:0] rd_a, rd_b;

    // halve the seed magnitude until it fits in a word
    assign seed_mag = seed_reg[DATA_W-1] ? (DATA_W'(0) - seed_reg) : seed_reg;

    always_comb
    begin
        if (seed_mag[31])
        begin
            seed_norm = seed_mag[31:4];
        end
        else if (seed_mag[30])
        begin
            seed_norm = seed_mag[30:3];
        end
        else if (seed_mag[29])
        begin
            seed_norm = seed_mag[29:2];
        end
        else if (seed_mag[28])
        begin
            seed_norm = seed_mag[28:1];
        end
        else
        begin
            seed_norm = seed_mag[27:0];
        end
    end

    // scatter stride modulo the table length
    always_comb
    begin
        sidx_sum = {1'b0, sidx_reg} + (IDX_W+1)'(SCATTER);
        if (sidx_sum >= (IDX_W+1)'(LAG_LONG))
        begin
            sidx_sum = sidx_sum - (IDX_W+1)'(LAG_LONG);
        end
    end

    assign partner = (k_reg < IDX_W'(LAG_SHORT)) ? (k_reg + IDX_W'(LAG_DIFF))
                                                 : (k_reg - IDX_W'(LAG_SHORT));

    // table access
    assign ram_we      = cmd.seed_step | cmd.rf_write;
    assign ram_waddr   = cmd.seed_step ? sidx_reg : k_reg;
    assign ram_wdata   = cmd.seed_step ? b_reg : (rd_a - rd_b);
    assign ram_raddr_a = cmd.draw_read ? ptr_reg : k_reg;

    lsur_ram #(
        .WIDTH (WORD_W),
        .DEPTH (LAG_LONG)
    ) u_table (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .rdata_a (rd_a),
        .raddr_b (partner),
        .rdata_b (rd_b)
    );

    // one halving step of the fraction product
    assign p_sum = {1'b0, p_reg} + {1'b0, q_reg};

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        sidx_next = sidx_reg;
        scnt_next = scnt_reg;
        k_next    = k_reg;
        ptr_next  = ptr_reg;
        step_next = step_reg;
        p_next    = p_reg;
        f_next    = f_reg;
        if (cmd.seed_load)
        begin
            a_next    = seed_norm;
            b_next    = WORD_W'(1);
            sidx_next = '0;
            scnt_next = '0;
            k_next    = '0;
        end
        if (cmd.seed_step)
        begin
            a_next    = b_reg;
            b_next    = a_reg - b_reg;
            sidx_next = sidx_sum[IDX_W-1:0];
            scnt_next = scnt_reg + IDX_W'(1);
        end
        if (cmd.rf_write)
        begin
            if (k_reg == IDX_LAST)
            begin
                k_next   = '0;
                ptr_next = IDX_LAST;
            end
            else
            begin
                k_next = k_reg + IDX_W'(1);
            end
        end
        if (cmd.draw_start && (ptr_reg != '0))
        begin
            ptr_next = ptr_reg - IDX_W'(1);
        end
        if (cmd.scale_load)
        begin
            f_next    = rd_a;
            p_next    = HALF_ONE;
            step_next = '0;
        end
        if (cmd.scale_step)
        begin
            p_next    = f_reg[0] ? p_sum[DATA_W:1] : {1'b0, p_reg[DATA_W-1:1]};
            f_next    = {1'b0, f_reg[WORD_W-1:1]};
            step_next = step_reg + STEP_W'(1);
        end
    end

    // saturate, then zero on a hit of the bound, else apply the sign
    assign y_sat  = p_reg[DATA_W-1] ? INT_TOP : p_reg;
    assign result = (y_sat == q_reg) ? '0 :
                    (neg_reg ? (DATA_W'(0) - y_sat) : y_sat);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg   <= '0;
            scnt_reg   <= '0;
            k_reg      <= '0;
            ptr_reg    <= IDX_LAST;
            step_reg   <= '0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                seed_reg <= cfg_wdata;
            end
            scnt_reg <= scnt_next;
            k_reg    <= k_next;
            ptr_reg  <= ptr_next;
            step_reg <= step_next;
            if (cmd.out_load)
            begin
                mvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                mvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        sidx_reg <= sidx_next;
        p_reg    <= p_next;
        f_reg    <= f_next;
        if (cmd.draw_start)
        begin
            neg_reg <= s_tdata[DATA_W-1];
            q_reg   <= s_tdata[DATA_W-1] ? (DATA_W'(0) - s_tdata) : s_tdata;
        end
        if (cmd.out_load)
        begin
            mdata_reg <= result;
        end
    end

    assign sts.seed_last  = (scnt_reg == IDX_LAST);
    assign sts.rf_last    = (k_reg == IDX_LAST);
    assign sts.ptr_zero   = (ptr_reg == '0);
    assign sts.scale_last = (step_reg == STEP_LAST);
    assign sts.out_free   = !mvalid_reg || m_tready;

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

endmodule

### design/lagged_subtractive_uniform_rng.sv
// Top level of the lagged subtractive (55, 24) uniform random generator.
// Depends on lsur_pkg, lsur_ctrl, lsur_dp (which holds lsur_ram).
//
//  channel  | direction | signals                      | word
//  ---------+-----------+------------------------------+----------------------------
//  request  | in        | s_tvalid s_tready s_tdata    | bound, signed 32 bits
//  result   | out       | m_tvalid m_tready m_tdata    | value, signed 32 bits
//  seed     | in        | cfg_we cfg_wdata             | seed, signed 32 bits
//
// A draw runs from its acceptance through the registered table read, 28
// halving steps of the fraction product and the load of the output register.
// Every 55th draw first refills the table: 55 entries, each by a read of
// both lags and then a write.
// Reset or a seed write runs seeding: a seed load, 55 scattered writes and
// 3 refill passes, with s_tready low throughout.
// A result waiting in the output register does not block the next request;
// only the final load of a draw waits for the output to be free.
module lagged_subtractive_uniform_rng
    import lsur_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // request stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,    // [31:0] bound
    // result stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,    // [31:0] value
    // seed register write
    input  logic              cfg_we,
    input  logic [DATA_W-1:0] cfg_wdata
);

    cmd_t cmd;
    sts_t sts;

    // sequence seeding, refill passes and draws
    lsur_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // hold the table, advance the recurrences, form the scaled draw
    lsur_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule

### dv/tb_lagged_subtractive_uniform_rng.sv
// Testbench for lagged_subtractive_uniform_rng: directed and random bound words
// checked against an in-bench model of the (55, 24) subtractive table and scaling.
// Depends on lsur_pkg and the design top level; self-checking, no external files.
module tb_lagged_subtractive_uniform_rng;

    timeunit 1ns;
    timeprecision 1ps;

    import lsur_pkg::*;

    // Clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // DUT ports, every input known from time zero
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata   = '0;   // [31:0] bound
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [DATA_W-1:0] m_tdata;          // [31:0] value
    logic              cfg_we    = 1'b0;
    logic [DATA_W-1:0] cfg_wdata = '0;   // [31:0] seed

    // Idle knobs, in percent of cycles
    int send_idle_pct   = 0;
    int ready_stall_pct = 0;

    int error_count = 0;

    // Model state: lag table, read pointer, and draws still owed by the DUT
    logic [WORD_W-1:0] lag_words [LAG_LONG];
    logic [IDX_W-1:0]  draw_ptr;
    logic [DATA_W-1:0] pending_values [$];

    lagged_subtractive_uniform_rng u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Table model
    // ------------------------------------------------------------------

    // One refill pass: the low 24 entries take the lag-31 partner, the rest
    // take the lag-24 partner that was just rewritten. Subtraction wraps at
    // the 28-bit word width.
    function automatic void refill_lag_table();
        for (int k = 0; k < LAG_SHORT; k++)
            lag_words[k] = lag_words[k] - lag_words[k + LAG_DIFF];
        for (int k = LAG_SHORT; k < LAG_LONG; k++)
            lag_words[k] = lag_words[k] - lag_words[k - LAG_SHORT];
        draw_ptr = IDX_LAST;
    endfunction

    // Seeding: take the seed magnitude (the most negative seed stays 2^31),
    // halve it below 2^28, run the recurrence scattered by stride 21, then
    // refill three times.
    function automatic void reseed_lag_table(logic [DATA_W-1:0] seed);
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] t;
        a = seed[DATA_W-1] ? (32'd0 - seed) : seed;
        while (a >= 32'h1000_0000)
            a = a >> 1;
        b = 32'd1;
        for (int i = 0; i < LAG_LONG; i++)
        begin
            t = b;
            b = (a - b) & 32'h0FFF_FFFF;
            a = t;
            lag_words[(i * SCATTER) % LAG_LONG] = a[WORD_W-1:0];
        end
        repeat (3) refill_lag_table();
    endfunction

    // Magnitude times frac / 2^28 by 28 halving steps. Magnitudes of 2^30 and
    // up use the wide form so the running sum never leaves 32 bits; anything
    // above the largest positive integer saturates.
    function automatic logic [DATA_W-1:0] scale_fraction(logic [DATA_W-1:0] mag,
                                                         logic [WORD_W-1:0] frac);
        logic [WORD_W:0]   f;
        logic [DATA_W-1:0] p;
        logic [DATA_W-1:0] sum;
        f = {1'b1, frac};
        p = HALF_ONE;
        for (int s = 0; s < FRAC_STEPS; s++)
        begin
            if (mag < 32'h4000_0000)
            begin
                sum = p + mag;
                p   = f[0] ? (sum >> 1) : (p >> 1);
            end
            else
            begin
                sum = mag - p;
                p   = f[0] ? (p + (sum >> 1)) : (p >> 1);
            end
            f = f >> 1;
        end
        if (p > INT_TOP)
            p = INT_TOP;
        return p;
    endfunction

    // Step the pointer (refill when it sits at zero), draw, and apply the sign
    // rule: a product equal to the magnitude gives zero.
    function automatic logic [DATA_W-1:0] predict_draw(logic [DATA_W-1:0] bound);
        logic              neg;
        logic [DATA_W-1:0] mag;
        logic [DATA_W-1:0] y;
        neg = bound[DATA_W-1];
        mag = neg ? (32'd0 - bound) : bound;
        if (draw_ptr == '0)
            refill_lag_table();
        else
            draw_ptr = draw_ptr - 1'b1;
        y = scale_fraction(mag, lag_words[draw_ptr]);
        if (y == mag)
            return '0;
        return neg ? (32'd0 - y) : y;
    endfunction

    // ------------------------------------------------------------------
    // Result checker and receiver stalls
    // ------------------------------------------------------------------

    // Compare each accepted value word with the oldest prediction, then pick
    // the next cycle's ready. Reading m_tready here sees the value at the edge.
    always @(posedge clk)
    begin : value_check
        logic [DATA_W-1:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_values.size() == 0)
            begin
                $error("value: no word expected, got %h", m_tdata);
                error_count++;
            end
            else
            begin
                want = pending_values.pop_front();
                if (m_tdata !== want)
                begin
                    $error("value: expected %h, actual %h", want, m_tdata);
                    error_count++;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= ready_stall_pct);
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one bound word, with random idle cycles ahead of it. Lower valid
    // only inside an idle cycle, so back-to-back words keep it high.
    task automatic send_bound(input logic [DATA_W-1:0] bound);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= bound;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_values.push_back(predict_draw(bound));
    endtask

    // Drop valid after the last word and hold until every draw has come back,
    // plus a short tail so a late stray word would still be caught.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_values.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write the seed while idle; the DUT then reseeds with s_tready low,
    // which the next send simply waits out.
    task automatic write_seed(input logic [DATA_W-1:0] seed);
        cfg_we    <= 1'b1;
        cfg_wdata <= seed;
        @(posedge clk);
        cfg_we    <= 1'b0;
        reseed_lag_table(seed);
        @(posedge clk);
    endtask

    // Bounds weighted toward the interesting regions: full range, small
    // magnitudes, the integer extremes, the wide-form threshold at 2^30,
    // and powers of two.
    function automatic logic [DATA_W-1:0] random_bound();
        int                kind;
        logic [DATA_W-1:0] v;
        kind = $urandom_range(99);
        if (kind < 40)
            return $urandom;
        if (kind < 60)
            v = $urandom_range(1000);
        else if (kind < 75)
            return $urandom_range(1) ? (32'h7FFF_FFFF - $urandom_range(15))
                                     : (32'h8000_0000 + $urandom_range(15));
        else if (kind < 90)
            v = 32'h4000_0000 + $urandom_range(16) - 8;
        else
            v = 32'd1 << $urandom_range(31);
        return $urandom_range(1) ? (32'd0 - v) : v;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes on the reset seed: zero bound, unit bounds, both integer
    // extremes (the most negative takes the wide saturating form), and both
    // sides of the 2^30 wide-form threshold in each sign.
    task automatic test_bound_extremes();
        logic [DATA_W-1:0] bounds [12];
        bounds = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h8000_0001, 32'h3FFF_FFFF, 32'h4000_0000,
                   32'hC000_0000, 32'hC000_0001, 32'h0000_0002, 32'hFFFF_FFFE};
        foreach (bounds[i])
            send_bound(bounds[i]);
        drain_results();
    endtask

    // Seed extremes: most negative (magnitude 2^31), largest positive, minus
    // one, one, and both sides of the 2^28 halving threshold.
    task automatic test_seed_extremes();
        logic [DATA_W-1:0] seeds [6];
        seeds = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                  32'h0000_0001, 32'h1000_0000, 32'h0FFF_FFFF};
        foreach (seeds[i])
        begin
            write_seed(seeds[i]);
            send_bound(32'h7FFF_FFFF);
            send_bound(random_bound());
            drain_results();
        end
    endtask

    // Random bounds under one idle pattern, split across two random seeds so
    // each seed runs well past several table refills.
    task automatic test_random_draws(input int idle_pct, input int stall_pct,
                                     input int per_seed);
        send_idle_pct   = idle_pct;
        ready_stall_pct = stall_pct;
        repeat (2)
        begin
            write_seed($urandom);
            repeat (per_seed)
                send_bound(random_bound());
            drain_results();
        end
        send_idle_pct   = 0;
        ready_stall_pct = 0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        // Reset seeds the table from seed 0; model the same.
        reseed_lag_table('0);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_bound_extremes();
        test_seed_extremes();
        test_random_draws(0, 0, 181);
        test_random_draws(75, 0, 181);
        test_random_draws(0, 75, 181);
        test_random_draws(31, 31, 181);

        if (error_count == 0)
            $display("** lagged_subtractive_uniform_rng: PASSED **");
        else
            $display("** lagged_subtractive_uniform_rng: FAILED **");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #10_000_000;
        $display("** lagged_subtractive_uniform_rng: FAILED **");
        $finish;
    end

endmodule
